// ===== rtl/flc_pkg.sv =====
// Shared types and constants for the full linear convolution block.
// Used by flc_ctrl, flc_datapath and full_linear_convolution_top.
package flc_pkg;

	localparam int TAP_INDEX_BITS = 6;
	localparam int TAP_COUNT_BITS = 7;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic coef_we;    // write the beat's value into the coefficient store
		logic shift;      // push a sample into history, clear accumulator
		logic zero;       // pushed sample is a tail zero
		logic issue;      // read one tap pair into the MAC pipe
		logic load_out;   // move accumulator to output register
		logic out_last;   // tlast for the loaded result
		logic clear_hist; // block done, history reads as zero again
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/flc_ctrl.sv =====
// Sequencer for the convolution block: input handshake, tap loop and tail results.
// Depends on flc_pkg for the command/status structs and opcode constants.
module flc_ctrl #(
	parameter int MAX_TAPS = 64,
	localparam int TW = $clog2(MAX_TAPS + 1),
	localparam int IW = $clog2(MAX_TAPS)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [flc_pkg::TAP_COUNT_BITS-1:0] cfg_wdata,
	input  logic                              in_valid,
	input  logic                              in_opcode,
	input  logic                              in_last,
	output logic                              in_ready,
	input  flc_pkg::status_t                  stat,
	output flc_pkg::cmd_t                     cmd,
	output logic [IW-1:0]                     rd_tap
);

	localparam int CW   = flc_pkg::TAP_COUNT_BITS;
	localparam int CMPW = (TW > CW) ? TW : CW;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MAC    = 3'd1;
	localparam logic [2:0] ST_DRAIN  = 3'd2;
	localparam logic [2:0] ST_FINISH = 3'd3;
	localparam logic [2:0] ST_TAIL   = 3'd4;

	logic [2:0]    state_q;
	logic [CW-1:0] tap_count_q;
	logic [TW-1:0] taps_q;
	logic [TW-1:0] rem_q;
	logic [IW-1:0] j_q;
	logic          last_q;

	logic [CMPW-1:0] cfg_ext;
	logic [TW-1:0]   eff_taps;
	logic            accept_sample;
	logic            last_tap;
	logic            block_done;

	// zero counts as one tap, anything above the store depth saturates
	always_comb begin
		cfg_ext = CMPW'(tap_count_q);
		if (cfg_ext == '0) begin
			eff_taps = TW'(1);
		end else if (cfg_ext > CMPW'(MAX_TAPS)) begin
			eff_taps = TW'(MAX_TAPS);
		end else begin
			eff_taps = TW'(cfg_ext);
		end
	end

	assign in_ready      = (state_q == ST_IDLE);
	assign accept_sample = in_valid && in_ready && (in_opcode == flc_pkg::OP_SAMPLE);
	assign last_tap      = (TW'(j_q) == (taps_q - TW'(1)));
	assign block_done    = last_q && (rem_q == '0);
	assign rd_tap        = j_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_opcode == flc_pkg::OP_SAMPLE) begin
						cmd.shift = 1'b1;
					end else begin
						cmd.coef_we = 1'b1;
					end
				end
			end
			ST_MAC: begin
				cmd.issue = 1'b1;
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.load_out   = 1'b1;
					cmd.out_last   = block_done;
					cmd.clear_hist = block_done;
				end
			end
			ST_TAIL: begin
				cmd.shift = 1'b1;
				cmd.zero  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= CW'(1);
		end else if (cfg_we) begin
			tap_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			taps_q  <= TW'(1);
			rem_q   <= '0;
			j_q     <= '0;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept_sample) begin
						taps_q  <= eff_taps;
						last_q  <= in_last;
						rem_q   <= in_last ? (eff_taps - TW'(1)) : '0;
						j_q     <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (last_tap) begin
						state_q <= ST_DRAIN;
					end else begin
						j_q <= j_q + IW'(1);
					end
				end
				ST_DRAIN: begin
					if (!stat.pipe_busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (stat.out_free) begin
						if (rem_q != '0) begin
							rem_q   <= rem_q - TW'(1);
							state_q <= ST_TAIL;
						end else begin
							last_q  <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_TAIL: begin
					j_q     <= '0;
					state_q <= ST_MAC;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/flc_datapath.sv =====
// Coefficient store, circular sample history, MAC pipe and output register.
// Depends on flc_pkg for the command/status structs.
module flc_datapath #(
	parameter int MAX_TAPS    = 64,
	parameter int SAMPLE_BITS = 16,
	localparam int TW = $clog2(MAX_TAPS + 1),
	localparam int IW = $clog2(MAX_TAPS),
	localparam int RW = 2 * SAMPLE_BITS + $clog2(MAX_TAPS)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  flc_pkg::cmd_t                       cmd,
	input  logic [IW-1:0]                       rd_tap,
	output flc_pkg::status_t                    stat,
	input  logic [flc_pkg::TAP_INDEX_BITS-1:0]  tap_index,
	input  logic signed [SAMPLE_BITS-1:0]       value,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic signed [RW-1:0]                out_result,
	output logic                                out_last
);

	localparam int XW = (IW + 1 > flc_pkg::TAP_INDEX_BITS) ? IW + 1 : flc_pkg::TAP_INDEX_BITS;

	logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];

	logic [IW-1:0] newest_q;
	logic [IW-1:0] next_wr;
	logic [TW-1:0] fill_q;
	logic [IW-1:0] hist_rd;
	logic [IW:0]   wrap_rd;
	logic          idx_ok;

	logic                          v_s1, v_s2;
	logic                          mask_s1;
	logic signed [SAMPLE_BITS-1:0] coef_s1, hist_s1;
	logic signed [2*SAMPLE_BITS-1:0] prod_s2;
	logic signed [RW-1:0]          acc_q;

	logic                          out_valid_q;
	logic signed [RW-1:0]          out_result_q;
	logic                          out_last_q;

	assign next_wr = (newest_q == IW'(MAX_TAPS - 1)) ? '0 : newest_q + IW'(1);
	// age rd_tap sits rd_tap slots behind the newest entry, modulo the depth
	assign wrap_rd = {1'b0, newest_q} + (IW + 1)'(MAX_TAPS) - {1'b0, rd_tap};
	assign hist_rd = (newest_q >= rd_tap) ? (newest_q - rd_tap) : wrap_rd[IW-1:0];
	assign idx_ok  = (XW'(tap_index) < XW'(MAX_TAPS));

	always_ff @(posedge clk) begin
		if (cmd.coef_we && idx_ok) begin
			coef_mem[IW'(tap_index)] <= value;
		end
		coef_s1 <= coef_mem[rd_tap];
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			hist_mem[next_wr] <= cmd.zero ? '0 : value;
		end
		hist_s1 <= hist_mem[hist_rd];
	end

	// fill count stands in for clearing: ages at or past it read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q <= '0;
			fill_q   <= '0;
		end else begin
			if (cmd.shift) begin
				newest_q <= next_wr;
			end
			if (cmd.clear_hist) begin
				fill_q <= '0;
			end else if (cmd.shift && fill_q != TW'(MAX_TAPS)) begin
				fill_q <= fill_q + TW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		mask_s1 <= (TW'(rd_tap) < fill_q);
		if (mask_s1) begin
			prod_s2 <= coef_s1 * hist_s1;
		end else begin
			prod_s2 <= '0;
		end
		if (cmd.shift) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + RW'(prod_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_result_q <= acc_q;
			out_last_q   <= cmd.out_last;
		end
	end

	assign stat.pipe_busy = v_s1 | v_s2;
	assign stat.out_free  = !out_valid_q || out_ready;
	assign out_valid      = out_valid_q;
	assign out_result     = out_result_q;
	assign out_last       = out_last_q;

endmodule

// ===== rtl/full_linear_convolution_top.sv =====
// Full linear convolution: top level of controller and datapath.
// Depends on flc_pkg, flc_ctrl and flc_datapath.
//
// Usage:
//  s_axis carries items; tuser is the opcode (0 load coefficient, 1 sample),
//  tlast marks the last sample of a block. A load beat writes value into
//  coefficient tap_index and gives no result. A sample beat gives one
//  result beat on m_axis; a sample with tlast also gives tap_count-1 tail
//  beats, and m_axis tlast flags the block's final result.
//  cfg_we/cfg_wdata write tap_count (0 acts as 1, values above MAX_TAPS
//  saturate); write only while the block is idle.
//  Each result comes from one shared multiply-accumulate that walks the
//  taps, one per cycle, through a read-multiply-accumulate pipe; a tail
//  result first pushes a zero sample into the sample history.
//  Results sit in an output register, so a stalled receiver holds the
//  beat there; the next result waits for that register to free up and
//  s_axis_tready stays low until the whole item is delivered to it.
//  Reset clears the sample history (through a fill count), tap_count
//  becomes 1, coefficients stay undefined until loaded.
module full_linear_convolution_top #(
	parameter int MAX_TAPS    = 64,
	parameter int SAMPLE_BITS = 16,
	localparam int IW      = $clog2(MAX_TAPS),
	localparam int RW      = 2 * SAMPLE_BITS + $clog2(MAX_TAPS),
	localparam int IN_BITS = ((flc_pkg::TAP_INDEX_BITS + SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = ((RW + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [flc_pkg::TAP_COUNT_BITS-1:0] cfg_wdata,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [IN_BITS-1:0]                 s_axis_tdata,  // tap_index, value, zero pad
	input  logic                               s_axis_tuser,  // opcode
	input  logic                               s_axis_tlast,  // block_end
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [OUT_BITS-1:0]                m_axis_tdata,  // result, zero pad
	output logic                               m_axis_tlast   // last_result
);

	localparam int XB = flc_pkg::TAP_INDEX_BITS;

	flc_pkg::cmd_t    cmd;
	flc_pkg::status_t stat;
	logic [IW-1:0]    rd_tap;

	logic [XB-1:0]                 tap_index;
	logic signed [SAMPLE_BITS-1:0] value;
	logic signed [RW-1:0]          result;

	assign tap_index = s_axis_tdata[XB-1:0];
	assign value     = s_axis_tdata[XB +: SAMPLE_BITS];

	flc_ctrl #(
		.MAX_TAPS(MAX_TAPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (s_axis_tvalid),
		.in_opcode(s_axis_tuser),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd),
		.rd_tap   (rd_tap)
	);

	flc_datapath #(
		.MAX_TAPS   (MAX_TAPS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rd_tap    (rd_tap),
		.stat      (stat),
		.tap_index (tap_index),
		.value     (value),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_result(result),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = OUT_BITS'($unsigned(result));

endmodule
